// ===== rtl/core/pce_pkg.sv =====
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types, constants and helper functions for the particle constraint
// engine: item and result layouts, operation codes and fixed-point widths.
// ----------------------------------------------------------------------------
package pce_pkg;

    // Table size and fixed-point format.
    localparam int POINTS    = 64;
    localparam int PT_W      = $clog2(POINTS);
    localparam int MEM_DEPTH = POINTS * 4;
    localparam int MEM_AW    = PT_W + 2;
    localparam int FRAC_BITS = 16;
    localparam int W         = 32;

    // Datapath widths.
    localparam int DW      = W + 1;          // exact position difference
    localparam int MUL_W   = 36;             // multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;      // multiplier product width
    localparam int SQ_W    = 68;             // sum of three squares
    localparam int ROOT_W  = 36;             // square root result bits
    localparam int RAD_W   = 2 * ROOT_W;     // padded radicand
    localparam int SRW     = ROOT_W + 3;     // square root remainder
    localparam int QB      = 35;             // correction quotient bits
    localparam int DR_W    = QB + 1;         // divider remainder and divisor
    localparam int CW      = QB + 2;         // signed correction
    localparam int CNT_W   = 6;

    // Function codes.
    localparam logic [2:0] FN_WRITE     = 3'd0;
    localparam logic [2:0] FN_SET_VEL   = 3'd1;
    localparam logic [2:0] FN_FORCE     = 3'd2;
    localparam logic [2:0] FN_INTEGRATE = 3'd3;
    localparam logic [2:0] FN_CONSTRAIN = 3'd4;
    localparam logic [2:0] FN_READ      = 3'd5;

    // Constraint kinds.
    localparam logic [2:0] KIND_MAX_X = 3'd3;
    localparam logic [2:0] KIND_DIST  = 3'd6;
    localparam logic [2:0] KIND_BAD   = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_KIND  = 2'd1;
    localparam logic [1:0] ST_ZERO_DIST = 2'd2;

    // Datapath operations issued by the controller.
    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_RD_A      = 5'd1;
    localparam logic [4:0] OP_RD_B      = 5'd2;
    localparam logic [4:0] OP_WR_A      = 5'd3;
    localparam logic [4:0] OP_WR_B      = 5'd4;
    localparam logic [4:0] OP_WRPT      = 5'd5;
    localparam logic [4:0] OP_SETV      = 5'd6;
    localparam logic [4:0] OP_F_MUL     = 5'd7;
    localparam logic [4:0] OP_F_ACC     = 5'd8;
    localparam logic [4:0] OP_INT_V     = 5'd9;
    localparam logic [4:0] OP_INT_P     = 5'd10;
    localparam logic [4:0] OP_CLAMP     = 5'd11;
    localparam logic [4:0] OP_BADKIND   = 5'd12;
    localparam logic [4:0] OP_DIFF      = 5'd13;
    localparam logic [4:0] OP_SQ_MUL    = 5'd14;
    localparam logic [4:0] OP_SQ_ACC    = 5'd15;
    localparam logic [4:0] OP_SQRT_INIT = 5'd16;
    localparam logic [4:0] OP_SQRT_STEP = 5'd17;
    localparam logic [4:0] OP_ZERO      = 5'd18;
    localparam logic [4:0] OP_C_MUL     = 5'd19;
    localparam logic [4:0] OP_C_LOAD    = 5'd20;
    localparam logic [4:0] OP_DIV_STEP  = 5'd21;
    localparam logic [4:0] OP_APPLY     = 5'd22;
    localparam logic [4:0] OP_OUT       = 5'd23;

    typedef struct packed {
        logic [2:0]          func;
        logic [5:0]          point_a;
        logic [5:0]          point_b;
        logic [2:0]          kind;
        logic signed [31:0]  limit_value;
        logic signed [31:0]  vec_x;
        logic signed [31:0]  vec_y;
        logic signed [31:0]  vec_z;
        logic [31:0]         inv_mass;
        logic                batch_end;
    } pce_in_t;

    typedef struct packed {
        logic signed [31:0]  out_px;
        logic signed [31:0]  out_py;
        logic signed [31:0]  out_pz;
        logic signed [31:0]  out_vx;
        logic signed [31:0]  out_vy;
        logic signed [31:0]  out_vz;
        logic [1:0]          status;
        logic                pass_done;
    } pce_out_t;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] axis;
        logic       capture;
    } pce_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] kind;
        logic       root_zero;
    } pce_stat_t;

    // Saturate a wide signed value to a 32-bit signed word.
    function automatic logic signed [W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-W:0] top;
        top = v[PROD_W-1:W-1];
        if (&top || ~|top)
            return v[W-1:0];
        else if (v[PROD_W-1])
            return {1'b1, {(W-1){1'b0}}};
        else
            return {1'b0, {(W-1){1'b1}}};
    endfunction

endpackage

// ===== rtl/core/pce_ctrl.sv =====
// ----------------------------------------------------------------------------
// pce_ctrl
// Sequencer for the particle constraint engine. Steps the datapath through
// the load, compute and write-back phases of one item and owns both
// handshakes.
// ----------------------------------------------------------------------------
module pce_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    output logic                result_valid,
    input  logic                result_stall,
    input  pce_pkg::pce_stat_t  stat,
    output pce_pkg::pce_cmd_t   cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RD_A    = 5'd1;
    localparam logic [4:0] S_RD_B    = 5'd2;
    localparam logic [4:0] S_WAIT    = 5'd3;
    localparam logic [4:0] S_ONE     = 5'd4;
    localparam logic [4:0] S_F_MUL   = 5'd5;
    localparam logic [4:0] S_F_ACC   = 5'd6;
    localparam logic [4:0] S_INT_V   = 5'd7;
    localparam logic [4:0] S_INT_P   = 5'd8;
    localparam logic [4:0] S_DIFF    = 5'd9;
    localparam logic [4:0] S_SQ_MUL  = 5'd10;
    localparam logic [4:0] S_SQ_ACC  = 5'd11;
    localparam logic [4:0] S_SQ_INIT = 5'd12;
    localparam logic [4:0] S_SQRT    = 5'd13;
    localparam logic [4:0] S_CHECK   = 5'd14;
    localparam logic [4:0] S_C_MUL   = 5'd15;
    localparam logic [4:0] S_C_LOAD  = 5'd16;
    localparam logic [4:0] S_DIV     = 5'd17;
    localparam logic [4:0] S_APPLY   = 5'd18;
    localparam logic [4:0] S_WR_A    = 5'd19;
    localparam logic [4:0] S_WR_B    = 5'd20;
    localparam logic [4:0] S_DONE    = 5'd21;

    localparam logic [pce_pkg::CNT_W-1:0] LAST_AXIS = pce_pkg::CNT_W'(2);
    localparam logic [pce_pkg::CNT_W-1:0] LAST_ROOT = pce_pkg::CNT_W'(pce_pkg::ROOT_W - 1);
    localparam logic [pce_pkg::CNT_W-1:0] LAST_DIV  = pce_pkg::CNT_W'(pce_pkg::QB - 1);

    logic [4:0]                  state_reg, state_next;
    logic [pce_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        is_dist;

    assign is_dist = (stat.func == pce_pkg::FN_CONSTRAIN) && (stat.kind == pce_pkg::KIND_DIST);
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next-state logic and command decode.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && result_stall;
        cmd.op         = pce_pkg::OP_NOP;
        cmd.axis       = cnt_reg[1:0];
        cmd.capture    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_RD_A;
                end
            end
            S_RD_A:
            begin
                cmd.op = pce_pkg::OP_RD_A;
                if (cnt_reg == LAST_AXIS)
                begin
                    cnt_next   = '0;
                    state_next = is_dist ? S_RD_B : S_WAIT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_RD_B:
            begin
                cmd.op = pce_pkg::OP_RD_B;
                if (cnt_reg == LAST_AXIS)
                begin
                    cnt_next   = '0;
                    state_next = S_WAIT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_WAIT:
            begin
                // The last read beat lands in the working registers here.
                cnt_next = '0;
                case (stat.func)
                    pce_pkg::FN_FORCE:     state_next = S_F_MUL;
                    pce_pkg::FN_INTEGRATE: state_next = S_INT_V;
                    pce_pkg::FN_CONSTRAIN: state_next = is_dist ? S_DIFF : S_ONE;
                    default:               state_next = S_ONE;
                endcase
            end
            S_ONE:
            begin
                case (stat.func)
                    pce_pkg::FN_WRITE:     cmd.op = pce_pkg::OP_WRPT;
                    pce_pkg::FN_SET_VEL:   cmd.op = pce_pkg::OP_SETV;
                    pce_pkg::FN_CONSTRAIN:
                        cmd.op = (stat.kind == pce_pkg::KIND_BAD) ? pce_pkg::OP_BADKIND
                                                                  : pce_pkg::OP_CLAMP;
                    default:               cmd.op = pce_pkg::OP_NOP;
                endcase
                state_next = S_WR_A;
            end
            S_F_MUL:
            begin
                cmd.op     = pce_pkg::OP_F_MUL;
                state_next = S_F_ACC;
            end
            S_F_ACC:
            begin
                cmd.op = pce_pkg::OP_F_ACC;
                if (cnt_reg == LAST_AXIS)
                begin
                    cnt_next   = '0;
                    state_next = S_WR_A;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_F_MUL;
                end
            end
            S_INT_V:
            begin
                cmd.op     = pce_pkg::OP_INT_V;
                state_next = S_INT_P;
            end
            S_INT_P:
            begin
                cmd.op     = pce_pkg::OP_INT_P;
                state_next = S_WR_A;
            end
            S_DIFF:
            begin
                cmd.op     = pce_pkg::OP_DIFF;
                state_next = S_SQ_MUL;
            end
            S_SQ_MUL:
            begin
                cmd.op     = pce_pkg::OP_SQ_MUL;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                cmd.op = pce_pkg::OP_SQ_ACC;
                if (cnt_reg == LAST_AXIS)
                begin
                    cnt_next   = '0;
                    state_next = S_SQ_INIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_SQ_MUL;
                end
            end
            S_SQ_INIT:
            begin
                cmd.op     = pce_pkg::OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = pce_pkg::OP_SQRT_STEP;
                if (cnt_reg == LAST_ROOT)
                begin
                    cnt_next   = '0;
                    state_next = S_CHECK;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_CHECK:
            begin
                // Coincident points leave the table untouched.
                cnt_next = '0;
                if (stat.root_zero)
                begin
                    cmd.op     = pce_pkg::OP_ZERO;
                    state_next = S_WR_A;
                end
                else
                    state_next = S_C_MUL;
            end
            S_C_MUL:
            begin
                cmd.op     = pce_pkg::OP_C_MUL;
                state_next = S_C_LOAD;
            end
            S_C_LOAD:
            begin
                cmd.op = pce_pkg::OP_C_LOAD;
                if (cnt_reg == LAST_AXIS)
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_C_MUL;
                end
            end
            S_DIV:
            begin
                cmd.op = pce_pkg::OP_DIV_STEP;
                if (cnt_reg == LAST_DIV)
                begin
                    cnt_next   = '0;
                    state_next = S_APPLY;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_APPLY:
            begin
                cmd.op     = pce_pkg::OP_APPLY;
                cnt_next   = '0;
                state_next = S_WR_A;
            end
            S_WR_A:
            begin
                cmd.op = pce_pkg::OP_WR_A;
                if (cnt_reg == LAST_AXIS)
                begin
                    cnt_next   = '0;
                    state_next = is_dist ? S_WR_B : S_DONE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_WR_B:
            begin
                cmd.op = pce_pkg::OP_WR_B;
                if (cnt_reg == LAST_AXIS)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DONE:
            begin
                // Load the output register once the previous beat has left.
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.op         = pce_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/pce_datapath.sv =====
// ----------------------------------------------------------------------------
// pce_datapath
// Particle tables, working registers, the shared multiplier, a bit-serial
// square root and three bit-serial divider lanes, driven one command a cycle.
// ----------------------------------------------------------------------------
module pce_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  pce_pkg::pce_in_t    item,
    input  pce_pkg::pce_cmd_t   cmd,
    output pce_pkg::pce_stat_t  stat,
    output pce_pkg::pce_out_t   result
);

    pce_pkg::pce_in_t                       item_reg;
    pce_pkg::pce_out_t                      out_reg;

    // Particle tables, addressed by {point, axis}; inverse mass by point.
    logic signed [pce_pkg::W-1:0]           pos_mem [pce_pkg::MEM_DEPTH];
    logic signed [pce_pkg::W-1:0]           vel_mem [pce_pkg::MEM_DEPTH];
    logic signed [pce_pkg::W-1:0]           acc_mem [pce_pkg::MEM_DEPTH];
    logic [pce_pkg::W-1:0]                  im_mem  [pce_pkg::POINTS];
    logic signed [pce_pkg::W-1:0]           pos_rdata, vel_rdata, acc_rdata;
    logic [pce_pkg::W-1:0]                  im_rdata;

    // Working registers.
    logic signed [pce_pkg::W-1:0]           pa_reg [3];
    logic signed [pce_pkg::W-1:0]           pb_reg [3];
    logic signed [pce_pkg::W-1:0]           va_reg [3];
    logic signed [pce_pkg::W-1:0]           aa_reg [3];
    logic [pce_pkg::W-1:0]                  im_reg;
    logic [1:0]                             status_reg;
    logic signed [pce_pkg::DW-1:0]          diff_reg [3];
    logic signed [pce_pkg::PROD_W-1:0]      prod_reg;
    logic [pce_pkg::SQ_W-1:0]               sum_reg;
    logic [pce_pkg::RAD_W-1:0]              rad_reg;
    logic [pce_pkg::SRW-1:0]                srem_reg;
    logic [pce_pkg::ROOT_W-1:0]             root_reg;
    logic [pce_pkg::QB-1:0]                 num_reg  [3];
    logic [pce_pkg::DR_W-1:0]               drem_reg [3];
    logic [pce_pkg::QB-1:0]                 quo_reg  [3];
    logic                                   csign_reg [3];

    // Delayed capture of registered table reads.
    logic                                   ld_a_reg, ld_b_reg;
    logic [1:0]                             ld_axis_reg;

    logic [pce_pkg::PT_W-1:0]               pt_a, pt_b;
    logic [pce_pkg::MEM_AW-1:0]             pos_raddr, pos_waddr, pa_addr;
    logic                                   pos_we, pa_we, im_we;
    logic signed [pce_pkg::W-1:0]           pos_wdata;

    logic signed [pce_pkg::W-1:0]           vec_ax;
    logic signed [pce_pkg::MUL_W-1:0]       mul_a, mul_b, dl;
    logic signed [pce_pkg::PROD_W-1:0]      force_sh;
    logic signed [pce_pkg::W-1:0]           force_acc;
    logic                                   prod_neg;
    logic [pce_pkg::PROD_W-1:0]             prod_mag;
    logic [pce_pkg::SRW-1:0]                rem_sh, trial;
    logic [pce_pkg::DR_W-1:0]               den;
    logic [pce_pkg::DR_W:0]                 dsh [3];
    logic signed [pce_pkg::CW-1:0]          corr [3];
    logic [1:0]                             clamp_ax;
    logic                                   clamp_low;

    function automatic logic signed [pce_pkg::W-1:0] vec_sel(
        input pce_pkg::pce_in_t it,
        input logic [1:0]       ax
    );
        case (ax)
            2'd0:    return it.vec_x;
            2'd1:    return it.vec_y;
            default: return it.vec_z;
        endcase
    endfunction

    assign pt_a = item_reg.point_a[pce_pkg::PT_W-1:0];
    assign pt_b = item_reg.point_b[pce_pkg::PT_W-1:0];

    assign stat.func      = item_reg.func;
    assign stat.kind      = item_reg.kind;
    assign stat.root_zero = (root_reg == '0);
    assign result         = out_reg;

    // Table port addressing.
    assign pos_raddr = {(cmd.op == pce_pkg::OP_RD_B) ? pt_b : pt_a, cmd.axis};
    assign pos_waddr = {(cmd.op == pce_pkg::OP_WR_B) ? pt_b : pt_a, cmd.axis};
    assign pa_addr   = {pt_a, cmd.axis};
    assign pos_we    = (cmd.op == pce_pkg::OP_WR_A) || (cmd.op == pce_pkg::OP_WR_B);
    assign pa_we     = (cmd.op == pce_pkg::OP_WR_A);
    assign im_we     = pa_we && (cmd.axis == 2'd0);
    assign pos_wdata = (cmd.op == pce_pkg::OP_WR_B) ? pb_reg[cmd.axis] : pa_reg[cmd.axis];

    // Table memories with one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_waddr] <= pos_wdata;
        if (pa_we)
        begin
            vel_mem[pa_addr] <= va_reg[cmd.axis];
            acc_mem[pa_addr] <= aa_reg[cmd.axis];
        end
        if (im_we)
            im_mem[pt_a] <= im_reg;
        pos_rdata <= pos_mem[pos_raddr];
        vel_rdata <= vel_mem[pa_addr];
        acc_rdata <= acc_mem[pa_addr];
        im_rdata  <= im_mem[pt_a];
    end

    // Read capture control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_a_reg    <= 1'b0;
            ld_b_reg    <= 1'b0;
            ld_axis_reg <= 2'd0;
        end
        else
        begin
            ld_a_reg    <= (cmd.op == pce_pkg::OP_RD_A);
            ld_b_reg    <= (cmd.op == pce_pkg::OP_RD_B);
            ld_axis_reg <= cmd.axis;
        end
    end

    // Multiplier operand selection.
    assign vec_ax = vec_sel(item_reg, cmd.axis);
    assign dl = $signed({1'b0, root_reg[pce_pkg::MUL_W-2:0]})
              - pce_pkg::MUL_W'(item_reg.limit_value);

    always_comb
    begin
        case (cmd.op)
            pce_pkg::OP_F_MUL:
            begin
                mul_a = pce_pkg::MUL_W'(vec_ax);
                mul_b = $signed({{(pce_pkg::MUL_W-pce_pkg::W){1'b0}}, im_reg});
            end
            pce_pkg::OP_C_MUL:
            begin
                mul_a = pce_pkg::MUL_W'(diff_reg[cmd.axis]);
                mul_b = dl;
            end
            default:
            begin
                mul_a = pce_pkg::MUL_W'(diff_reg[cmd.axis]);
                mul_b = pce_pkg::MUL_W'(diff_reg[cmd.axis]);
            end
        endcase
    end

    // Force scaling with floor, then a saturating accumulate.
    assign force_sh  = prod_reg >>> pce_pkg::FRAC_BITS;
    assign force_acc = pce_pkg::sat32(pce_pkg::PROD_W'(aa_reg[cmd.axis])
                     + pce_pkg::PROD_W'(pce_pkg::sat32(force_sh)));

    // Magnitude of the correction product for the divider lanes.
    assign prod_neg = prod_reg[pce_pkg::PROD_W-1];
    assign prod_mag = prod_neg ? pce_pkg::PROD_W'(-prod_reg) : pce_pkg::PROD_W'(prod_reg);

    // One square root digit per step.
    assign rem_sh = {srem_reg[pce_pkg::SRW-3:0], rad_reg[pce_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // Divider lanes share the divisor 2d.
    assign den = {root_reg[pce_pkg::QB-1:0], 1'b0};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dsh[k]  = {drem_reg[k], num_reg[k][pce_pkg::QB-1]};
            corr[k] = csign_reg[k] ? -$signed({2'b00, quo_reg[k]})
                                   :  $signed({2'b00, quo_reg[k]});
        end
    end

    // Clamp axis and direction.
    assign clamp_low = (item_reg.kind < pce_pkg::KIND_MAX_X);
    assign clamp_ax  = clamp_low ? item_reg.kind[1:0]
                                 : 2'(item_reg.kind - pce_pkg::KIND_MAX_X);

    // Working register updates.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg   <= item;
            status_reg <= pce_pkg::ST_OK;
        end

        if (ld_a_reg)
        begin
            pa_reg[ld_axis_reg] <= pos_rdata;
            va_reg[ld_axis_reg] <= vel_rdata;
            aa_reg[ld_axis_reg] <= acc_rdata;
            im_reg              <= im_rdata;
        end
        if (ld_b_reg)
            pb_reg[ld_axis_reg] <= pos_rdata;

        case (cmd.op)
            pce_pkg::OP_WRPT:
            begin
                pa_reg[0] <= item_reg.vec_x;
                pa_reg[1] <= item_reg.vec_y;
                pa_reg[2] <= item_reg.vec_z;
                for (int k = 0; k < 3; k++)
                begin
                    va_reg[k] <= '0;
                    aa_reg[k] <= '0;
                end
                im_reg <= item_reg.inv_mass;
            end
            pce_pkg::OP_SETV:
            begin
                va_reg[0] <= item_reg.vec_x;
                va_reg[1] <= item_reg.vec_y;
                va_reg[2] <= item_reg.vec_z;
            end
            pce_pkg::OP_F_MUL, pce_pkg::OP_SQ_MUL, pce_pkg::OP_C_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            pce_pkg::OP_F_ACC:
            begin
                aa_reg[cmd.axis] <= force_acc;
            end
            pce_pkg::OP_INT_V:
            begin
                for (int k = 0; k < 3; k++)
                    va_reg[k] <= pce_pkg::sat32(pce_pkg::PROD_W'(va_reg[k])
                                              + pce_pkg::PROD_W'(aa_reg[k]));
            end
            pce_pkg::OP_INT_P:
            begin
                for (int k = 0; k < 3; k++)
                    pa_reg[k] <= pce_pkg::sat32(pce_pkg::PROD_W'(pa_reg[k])
                                              + pce_pkg::PROD_W'(va_reg[k]));
            end
            pce_pkg::OP_CLAMP:
            begin
                if (clamp_low && (pa_reg[clamp_ax] < item_reg.limit_value))
                    pa_reg[clamp_ax] <= item_reg.limit_value;
                else if (!clamp_low && (pa_reg[clamp_ax] > item_reg.limit_value))
                    pa_reg[clamp_ax] <= item_reg.limit_value;
            end
            pce_pkg::OP_BADKIND:
            begin
                status_reg <= pce_pkg::ST_BAD_KIND;
            end
            pce_pkg::OP_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                    diff_reg[k] <= pce_pkg::DW'(pa_reg[k]) - pce_pkg::DW'(pb_reg[k]);
                sum_reg <= '0;
            end
            pce_pkg::OP_SQ_ACC:
            begin
                sum_reg <= sum_reg + prod_reg[pce_pkg::SQ_W-1:0];
            end
            pce_pkg::OP_SQRT_INIT:
            begin
                rad_reg  <= {{(pce_pkg::RAD_W-pce_pkg::SQ_W){1'b0}}, sum_reg};
                srem_reg <= '0;
                root_reg <= '0;
            end
            pce_pkg::OP_SQRT_STEP:
            begin
                rad_reg <= {rad_reg[pce_pkg::RAD_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    srem_reg <= rem_sh - trial;
                    root_reg <= {root_reg[pce_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= rem_sh;
                    root_reg <= {root_reg[pce_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            pce_pkg::OP_ZERO:
            begin
                status_reg <= pce_pkg::ST_ZERO_DIST;
            end
            pce_pkg::OP_C_LOAD:
            begin
                // The quotient fits in QB bits, so the top bits start as remainder.
                csign_reg[cmd.axis] <= prod_neg;
                num_reg[cmd.axis]   <= prod_mag[pce_pkg::QB-1:0];
                drem_reg[cmd.axis]  <= prod_mag[pce_pkg::QB +: pce_pkg::DR_W];
                quo_reg[cmd.axis]   <= '0;
            end
            pce_pkg::OP_DIV_STEP:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    num_reg[k] <= {num_reg[k][pce_pkg::QB-2:0], 1'b0};
                    if (dsh[k] >= {1'b0, den})
                    begin
                        drem_reg[k] <= pce_pkg::DR_W'(dsh[k] - {1'b0, den});
                        quo_reg[k]  <= {quo_reg[k][pce_pkg::QB-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[k] <= dsh[k][pce_pkg::DR_W-1:0];
                        quo_reg[k]  <= {quo_reg[k][pce_pkg::QB-2:0], 1'b0};
                    end
                end
            end
            pce_pkg::OP_APPLY:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pa_reg[k] <= pce_pkg::sat32(pce_pkg::PROD_W'(pa_reg[k])
                                              - pce_pkg::PROD_W'(corr[k]));
                    pb_reg[k] <= pce_pkg::sat32(pce_pkg::PROD_W'(pb_reg[k])
                                              + pce_pkg::PROD_W'(corr[k]));
                end
            end
            pce_pkg::OP_OUT:
            begin
                out_reg.out_px    <= pa_reg[0];
                out_reg.out_py    <= pa_reg[1];
                out_reg.out_pz    <= pa_reg[2];
                out_reg.out_vx    <= va_reg[0];
                out_reg.out_vy    <= va_reg[1];
                out_reg.out_vz    <= va_reg[2];
                out_reg.status    <= status_reg;
                out_reg.pass_done <= item_reg.batch_end;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/core/particle_constraint_engine.sv =====
// ----------------------------------------------------------------------------
// particle_constraint_engine
// Particle table, semi-implicit Euler integration, clamp/distance constraints.
//
// An item arrives on the item channel (item_valid / item_stall) and selects
// one operation on a table of 64 particles. Every item gives exactly one beat
// on the result channel (result_valid / result_stall): position and velocity
// of point_a after the operation, a status code and the batch_end echo.
// One item is worked at a time. Apply force does one multiply and
// accumulate per axis. A distance constraint runs the 36-step bit-serial
// square root and, unless the points coincide, the 35-step divider whose
// three lanes run in parallel. The tables have one port each, so loads
// and write-backs take one axis per cycle. The item channel stalls until
// the result is loaded, so a new item is accepted in the cycle after that,
// never while the previous item is still being worked.
// A finished beat waits in the output register while the next item is
// accepted; a new result is loaded only once the receiver has taken the
// previous beat. Reset clears the sequencer and the output valid; table
// contents are undefined until a point is written.
// ----------------------------------------------------------------------------
module particle_constraint_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  pce_pkg::pce_in_t    item,
    output logic                result_valid,
    input  logic                result_stall,
    output pce_pkg::pce_out_t   result
);

    pce_pkg::pce_cmd_t  cmd;
    pce_pkg::pce_stat_t stat;

    // Sequencer.
    pce_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Tables and arithmetic.
    pce_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule
